### design/tife_pkg.sv
// Shared types, byte codes and the byte classifier for the text line field extractor.
package tife_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'd11;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'd12;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_INDEX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_INDEX = 8'd1;

    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic       lf;
        logic       sep;
        logic       skip;
        logic       sign;
        logic       minus;
        logic       digit;
        logic [3:0] digit_val;
    } t_byte_class;

    function automatic t_byte_class classify(input logic [BYTE_W-1:0] c);
        t_byte_class k;
        logic [BYTE_W-1:0] d;
        d           = c - CH_ZERO;
        k.lf        = (c == CH_LF);
        k.sep       = (c == CH_SPACE) || (c == CH_CR);
        k.skip      = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
        k.sign      = (c == CH_PLUS) || (c == CH_MINUS);
        k.minus     = (c == CH_MINUS);
        k.digit     = (c >= CH_ZERO) && (c <= CH_NINE);
        k.digit_val = d[3:0];
        return k;
    endfunction

endpackage

### design/tife_in_stage.sv
// Input register: holds one classified byte until the parser takes it.
module tife_in_stage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_byte,
    input  logic                    i_out_free,
    output logic                    o_advance,
    output tife_pkg::t_byte_class   o_cls
);
    import tife_pkg::*;

    logic        r_valid;
    t_byte_class r_cls;

    // a line feed moves on only when the result register can take it
    assign o_advance = r_valid && (!r_cls.lf || i_out_free);
    assign o_ready   = !r_valid || o_advance;
    assign o_cls     = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cls <= classify(i_byte);
        end
    end

endmodule

### design/tife_parser.sv
// Token state and atoi-style conversion, one byte per cycle while i_advance is high.
module tife_parser #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  tife_pkg::t_byte_class   i_cls,
    input  logic [7:0]              i_x_index,
    input  logic [7:0]              i_y_index,
    output logic [VALUE_WIDTH-1:0]  o_x_next,
    output logic [VALUE_WIDTH-1:0]  o_y_next,
    output logic [7:0]              o_count_next
);
    import tife_pkg::*;

    localparam int unsigned SUM_W = VALUE_WIDTH + 4;
    localparam logic [SUM_W-1:0] TOP = SUM_W'(1) << (VALUE_WIDTH - 1);

    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_inside, n_inside;
    t_phase                 r_phase, n_phase;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [VALUE_WIDTH-1:0] r_x, r_y;

    logic                   tok_byte;
    logic                   finish;
    logic                   in_digits;
    logic [VALUE_WIDTH-1:0] value;
    logic [POS_W-1:0]       pos_after;
    logic [SUM_W-1:0]       mag_ext;
    logic [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]       limit;

    assign tok_byte = !i_cls.lf && !i_cls.sep;
    assign finish   = r_inside && (i_cls.lf || i_cls.sep);
    assign value    = r_neg ? (VALUE_WIDTH'(0) - r_mag) : r_mag;
    assign pos_after = (finish && (r_pos != POS_MAX)) ? r_pos + 1'b1 : r_pos;

    // times ten as two shifts, then add the digit
    assign mag_ext = SUM_W'(r_mag);
    assign sum     = (mag_ext << 3) + (mag_ext << 1) + SUM_W'(i_cls.digit_val);
    assign limit   = r_neg ? TOP : TOP - 1'b1;

    // next phase
    always_comb begin
        n_phase   = r_phase;
        in_digits = 1'b0;
        if (!tok_byte) begin
            n_phase = PH_SIGN;
        end else begin
            unique case (r_phase)
                PH_SIGN: begin
                    if (i_cls.skip) begin
                        n_phase = PH_SIGN;
                    end else if (i_cls.sign) begin
                        n_phase = PH_DIGITS;
                    end else begin
                        in_digits = 1'b1;
                        n_phase   = i_cls.digit ? PH_DIGITS : PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    in_digits = 1'b1;
                    n_phase   = i_cls.digit ? PH_DIGITS : PH_DONE;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // token data
    always_comb begin
        n_inside = r_inside;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_pos    = r_pos;
        if (!tok_byte) begin
            n_inside = 1'b0;
            n_neg    = 1'b0;
            n_mag    = '0;
            n_pos    = i_cls.lf ? '0 : pos_after;
        end else begin
            n_inside = 1'b1;
            if ((r_phase == PH_SIGN) && !i_cls.skip && i_cls.sign) begin
                n_neg = i_cls.minus;
            end
            if (in_digits && i_cls.digit) begin
                n_mag = (sum > limit) ? limit[VALUE_WIDTH-1:0] : sum[VALUE_WIDTH-1:0];
            end
        end
    end

    assign o_x_next = (finish && (r_pos == i_x_index)) ? value : r_x;
    assign o_y_next = (finish && (r_pos == i_y_index)) ? value : r_y;
    assign o_count_next = pos_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_inside <= 1'b0;
            r_phase  <= PH_SIGN;
            r_neg    <= 1'b0;
            r_mag    <= '0;
            r_x      <= '0;
            r_y      <= '0;
        end else if (i_advance) begin
            r_pos    <= n_pos;
            r_inside <= n_inside;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_mag    <= n_mag;
            r_x      <= o_x_next;
            r_y      <= o_y_next;
        end
    end

endmodule

### design/tife_out_reg.sv
// Result register: holds one finished line until the consumer takes it.
module tife_out_reg #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [VALUE_WIDTH-1:0]  i_x,
    input  logic [VALUE_WIDTH-1:0]  i_y,
    input  logic [7:0]              i_count,
    output logic                    o_free,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [VALUE_WIDTH-1:0]  o_x,
    output logic [VALUE_WIDTH-1:0]  o_y,
    output logic [7:0]              o_count
);
    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_x, r_y;
    logic [7:0]             r_count;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_count <= i_count;
        end
    end

endmodule

### design/text_line_int_field_extractor.sv
// Top level of the text line integer field extractor.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready   | i_rx_byte
//  out     | out       | o_out_valid / i_out_ready | o_x_value, o_y_value, o_token_count
//
// One byte per cycle sustained: each byte is classified into the input register and
// then applied to the token state by a shift-add times-ten step.
// A line feed yields its result in the output register when it is applied from the input register.
// Reset (synchronous, active low) clears the valid flags and the token state; token indexes return to 2 and 3.
// Only a line feed stalls: it waits in the input register while the previous result
// is still unsent, and other bytes keep flowing otherwise.
module text_line_int_field_extractor #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [7:0]              i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    // received bytes
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_rx_byte,
    // finished lines
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [VALUE_WIDTH-1:0]  o_x_value,
    output logic [VALUE_WIDTH-1:0]  o_y_value,
    output logic [7:0]              o_token_count
);
    import tife_pkg::*;

    logic [7:0]             r_x_index;
    logic [7:0]             r_y_index;

    logic                   out_free;
    logic                   advance;
    t_byte_class            cls;
    logic [VALUE_WIDTH-1:0] x_next;
    logic [VALUE_WIDTH-1:0] y_next;
    logic [7:0]             count_next;

    // configuration is always accepted; writes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_index <= 8'd2;
            r_y_index <= 8'd3;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_X_INDEX) begin
                r_x_index <= i_cfg_data;
            end
            if (i_cfg_index == CFG_Y_INDEX) begin
                r_y_index <= i_cfg_data;
            end
        end
    end

    // hold and classify the incoming byte
    tife_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_byte     (i_rx_byte),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_cls      (cls)
    );

    // advance the token state by one byte
    tife_parser #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_cls        (cls),
        .i_x_index    (r_x_index),
        .i_y_index    (r_y_index),
        .o_x_next     (x_next),
        .o_y_next     (y_next),
        .o_count_next (count_next)
    );

    // capture the line result when a line feed is applied
    tife_out_reg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && cls.lf),
        .i_x     (x_next),
        .i_y     (y_next),
        .i_count (count_next),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_x     (o_x_value),
        .o_y     (o_y_value),
        .o_count (o_token_count)
    );

endmodule

### verif/tife_line_checker.sv
// Line checker for the text line integer field extractor: predicts and compares results.
`timescale 1ns / 100ps

module tife_line_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [7:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [31:0]       i_x_value,
    input  logic [31:0]       i_y_value,
    input  logic [7:0]        i_token_count,
    output int unsigned       o_lines_owed,
    output int unsigned       o_mismatches
);
    import tife_pkg::*;

    localparam logic [7:0] X_INDEX_RESET = 8'd2;
    localparam logic [7:0] Y_INDEX_RESET = 8'd3;
    localparam logic [63:0] POS_LIMIT    = 64'h7FFF_FFFF;
    localparam logic [63:0] NEG_LIMIT    = 64'h8000_0000;

    typedef struct packed {
        logic [31:0] x_value;
        logic [31:0] y_value;
        logic [7:0]  token_count;
    } t_line_result;

    t_line_result owed_lines[$];
    int unsigned  mismatches = 0;

    // parser state, kept apart from the block
    logic [7:0]  x_sel;
    logic [7:0]  y_sel;
    logic [7:0]  tok_pos;
    logic        in_token;
    t_phase      conv_phase;
    logic        neg;
    logic [63:0] mag;
    logic [31:0] x_reg;
    logic [31:0] y_reg;

    function automatic void clear_token();
        in_token   = 1'b0;
        conv_phase = PH_SIGN;
        neg        = 1'b0;
        mag        = '0;
    endfunction

    // close the open token and latch its value into x and/or y
    function automatic void close_token();
        logic [31:0] v;
        if (in_token) begin
            v = neg ? 32'(-mag) : 32'(mag);
            if (tok_pos == x_sel) x_reg = v;
            if (tok_pos == y_sel) y_reg = v;
            if (tok_pos != POS_MAX) tok_pos = tok_pos + 8'd1;
            clear_token();
        end
    endfunction

    function automatic void advance_line_parser(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] lim;
        if (c == CH_LF) begin
            close_token();
            owed_lines.push_back('{x_value: x_reg, y_value: y_reg, token_count: tok_pos});
            tok_pos = '0;
            clear_token();
        end else if (c == CH_SPACE || c == CH_CR) begin
            close_token();
        end else begin
            in_token = 1'b1;
            if (conv_phase == PH_SIGN) begin
                if (c == CH_TAB || c == CH_VT || c == CH_FF) begin
                    // leading whitespace: stay before the sign
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    neg        = (c == CH_MINUS);
                    conv_phase = PH_DIGITS;
                end else begin
                    conv_phase = PH_DIGITS;
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        mag = 64'(c - CH_ZERO);
                    end else begin
                        conv_phase = PH_DONE;
                    end
                end
            end else if (conv_phase == PH_DIGITS) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    d   = 64'(c - CH_ZERO);
                    lim = neg ? NEG_LIMIT : POS_LIMIT;
                    if (mag > (lim - d) / 64'd10) mag = lim;
                    else mag = mag * 64'd10 + d;
                end else begin
                    conv_phase = PH_DONE;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_line_result want;
        if (!i_rst_n) begin
            x_sel   = X_INDEX_RESET;
            y_sel   = Y_INDEX_RESET;
            tok_pos = '0;
            x_reg   = '0;
            y_reg   = '0;
            clear_token();
            owed_lines.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_X_INDEX) x_sel = i_cfg_data;
                else if (i_cfg_index == CFG_Y_INDEX) y_sel = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) advance_line_parser(i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                if (owed_lines.size() == 0) begin
                    $error("line result with none owed: x %0d y %0d count %0d",
                           $signed(i_x_value), $signed(i_y_value), i_token_count);
                    mismatches++;
                end else begin
                    want = owed_lines.pop_front();
                    if (i_x_value !== want.x_value) begin
                        $error("x_value mismatch: expected %0d, actual %0d",
                               $signed(want.x_value), $signed(i_x_value));
                        mismatches++;
                    end
                    if (i_y_value !== want.y_value) begin
                        $error("y_value mismatch: expected %0d, actual %0d",
                               $signed(want.y_value), $signed(i_y_value));
                        mismatches++;
                    end
                    if (i_token_count !== want.token_count) begin
                        $error("token_count mismatch: expected %0d, actual %0d",
                               want.token_count, i_token_count);
                        mismatches++;
                    end
                end
            end
        end
        o_lines_owed <= owed_lines.size();
        o_mismatches <= mismatches;
    end

endmodule

### verif/tb_text_line_int_field_extractor.sv
// Testbench top for the text line integer field extractor: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb_text_line_int_field_extractor;
    import tife_pkg::*;

    localparam int unsigned VW             = 32;
    localparam int unsigned PHASE_BYTES    = 220;
    localparam int unsigned LONG_BYTES     = 700;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    // index the block does not decode; a write there must change nothing
    localparam logic [7:0] CFG_UNUSED_INDEX = 8'hFE;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [7:0]      i_cfg_index;
    logic [7:0]      i_cfg_data;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [7:0]      i_rx_byte;
    logic            o_out_valid;
    logic            i_out_ready;
    logic [VW-1:0]   o_x_value;
    logic [VW-1:0]   o_y_value;
    logic [7:0]      o_token_count;

    int unsigned     lines_owed;
    int unsigned     mismatches;

    // pacing knobs, in percent of cycles spent idle
    int unsigned     send_gap_pct;
    int unsigned     recv_gap_pct;
    // each increment asks the receiver for one long hold-off
    int unsigned     hold_requests;

    int unsigned     bytes_sent;
    int unsigned     quiet_cycles = 0;
    logic [7:0]      line_buf[$];
    string           boundary_nums[4] = '{"2147483647", "2147483648", "2147483649",
                                          "4294967295"};

    always #6 i_clk = ~i_clk;

    text_line_int_field_extractor #(
        .VALUE_WIDTH (VW)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_x_value     (o_x_value),
        .o_y_value     (o_y_value),
        .o_token_count (o_token_count)
    );

    tife_line_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_x_value     (o_x_value),
        .i_y_value     (o_y_value),
        .i_token_count (o_token_count),
        .o_lines_owed  (lines_owed),
        .o_mismatches  (mismatches)
    );

    // Any byte that is neither a separator nor a line feed, so it stays inside a token.
    function automatic logic [7:0] token_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_LF || c == CH_SPACE || c == CH_CR) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic push_digit();
        line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // 1..3 separators, mostly spaces with some carriage returns mixed in
    task automatic push_gap();
        repeat ($urandom_range(1, 3))
            line_buf.push_back(($urandom_range(0, 2) == 0) ? CH_CR : CH_SPACE);
    endtask

    // One token: usually a well-formed number, sometimes junk, sign-only or overflowing.
    task automatic push_token();
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r == 0) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(token_char());
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(0, 2))
                        0:       line_buf.push_back(CH_TAB);
                        1:       line_buf.push_back(CH_VT);
                        default: line_buf.push_back(CH_FF);
                    endcase
                end
            end
            case ($urandom_range(0, 3))
                0:       line_buf.push_back(CH_PLUS);
                1:       line_buf.push_back(CH_MINUS);
                default: ;
            endcase
            if (r == 1) begin
                // no digits at all: converts to zero
            end else if (r == 2) begin
                push_text(boundary_nums[$urandom_range(0, 3)]);
            end else if (r == 3) begin
                repeat ($urandom_range(10, 12)) push_digit();
            end else begin
                repeat ($urandom_range(1, 5)) push_digit();
            end
            // trailing junk stops the conversion; digits after it must be ignored
            if ($urandom_range(0, 5) == 0) begin
                line_buf.push_back(token_char());
                if ($urandom_range(0, 1) == 0) push_digit();
            end
        end
    endtask

    // Mostly well-formed lines; one in ten is raw noise up to the line feed.
    task automatic build_random_line();
        int unsigned kind;
        int unsigned n_tok;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_tok = (kind == 1) ? 0 : $urandom_range(1, 7);
            if ($urandom_range(0, 4) == 0) push_gap();
            for (int t = 0; t < n_tok; t++) begin
                push_token();
                if (t + 1 < n_tok) push_gap();
            end
            if ($urandom_range(0, 3) == 0) push_gap();
        end
        line_buf.push_back(CH_LF);
    endtask

    // Past 255 tokens so the position counter saturates and the last token wins.
    task automatic build_long_line();
        repeat ($urandom_range(256, 262)) begin
            if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_MINUS);
            push_digit();
            line_buf.push_back(CH_SPACE);
        end
        line_buf.push_back(CH_LF);
    endtask

    // Offer one byte; hold valid and payload until the transaction completes.
    // Valid is lowered only inside an idle gap, never on the step the next byte goes up.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        while (line_buf.size() > 0) send_byte(line_buf.pop_front());
    endtask

    task automatic write_config(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every owed line, then let the pipeline settle.
    // The first wait lets the checker count the last accepted line feed.
    task automatic drain_lines();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (lines_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random ready, plus a long hold-off whenever one is requested.
    initial begin : out_ready_drive
        int unsigned holds_served;
        holds_served = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // Watchdog: end the run when nothing completes on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned phase_start;
        logic [7:0]  x_pick;
        logic [7:0]  y_pick;
        logic        hold_issued;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_rx_byte     <= '0;
        send_gap_pct  <= 6;
        recv_gap_pct  <= 65;
        hold_requests <= 0;
        bytes_sent     = 0;
        hold_issued    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines under the reset indexes (x from token 2, y from token 3).
        // Empty line: registers come out untouched, count zero.
        line_buf.push_back(CH_LF);
        // CR as separator, byte zero as a plain token, tab before a plus sign
        push_text("a");
        line_buf.push_back(CH_CR);
        line_buf.push_back(8'h00);
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(CH_TAB);
        push_text("+12");
        line_buf.push_back(CH_LF);
        // byte 255, VT and FF skipped, junk ends digits, y from a bare number
        line_buf.push_back(8'hFF);
        push_text(" 5 ");
        line_buf.push_back(CH_VT);
        line_buf.push_back(CH_FF);
        push_text("-9x 8");
        line_buf.push_back(CH_LF);
        // sign without digits gives zero; y keeps its value since token 3 is missing
        push_text("a b +");
        line_buf.push_back(CH_LF);
        send_line();
        drain_lines();

        // Random phases, each with its own index setting and pacing.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       begin x_pick = 8'd0;   y_pick = 8'd1;   end
                1:       begin x_pick = 8'd255; y_pick = 8'd0;   end
                2:       begin x_pick = 8'd4;   y_pick = 8'd4;   end
                3:       begin x_pick = 8'd1;   y_pick = 8'd0;   end
                4:       begin
                    x_pick = 8'($urandom_range(0, 7));
                    y_pick = 8'($urandom_range(0, 7));
                end
                default: begin x_pick = 8'd255; y_pick = 8'd254; end
            endcase
            write_config(CFG_X_INDEX, x_pick);
            write_config(CFG_Y_INDEX, y_pick);
            if (ph == 3) write_config(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));

            // fast sender / slow receiver, then swapped, then full rate
            if (ph < 2) begin
                send_gap_pct <= 6;
                recv_gap_pct <= 65;
            end else if (ph < 4) begin
                send_gap_pct <= 65;
                recv_gap_pct <= 6;
            end else begin
                send_gap_pct <= 0;
                recv_gap_pct <= 0;
            end

            phase_start = bytes_sent;
            if (ph == 5) begin
                build_long_line();
                send_line();
            end
            while (bytes_sent - phase_start < ((ph == 5) ? LONG_BYTES : PHASE_BYTES)) begin
                // at full rate, stall the receiver mid-phase so the input backs up
                if (ph == 4 && !hold_issued && bytes_sent - phase_start > PHASE_BYTES / 3) begin
                    hold_requests <= hold_requests + 1;
                    hold_issued    = 1'b1;
                end
                build_random_line();
                send_line();
            end
            drain_lines();
        end

        if (mismatches == 0 && lines_owed == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
design/tife_pkg.sv
design/tife_in_stage.sv
design/tife_parser.sv
design/tife_out_reg.sv
design/text_line_int_field_extractor.sv
verif/tife_line_checker.sv
verif/tb_text_line_int_field_extractor.sv
